### src/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pls_pkg;

	localparam int VEC_W  = 16;
	localparam int COEF_W = 16;
	localparam int EXP_W  = 8;
	localparam int OUT_W  = 17;
	localparam int D_W    = 32;   // d = -(N.L), Q.28, never above 3*2^30
	localparam int DOT_W  = 37;   // positive r.(-V), Q.28
	localparam int NORM_W = 42;   // r.r, Q.28
	localparam int P_W    = 35;   // power term, Q.16, capped at 2^34
	localparam int H_W    = 36;   // cosine in Q.16, clamped at 2^35

	localparam logic [2:0] REG_DIFF_R  = 3'd0;
	localparam logic [2:0] REG_DIFF_G  = 3'd1;
	localparam logic [2:0] REG_DIFF_B  = 3'd2;
	localparam logic [2:0] REG_SPEC_R  = 3'd3;
	localparam logic [2:0] REG_SPEC_G  = 3'd4;
	localparam logic [2:0] REG_SPEC_B  = 3'd5;
	localparam logic [2:0] REG_SHINE   = 3'd6;

	localparam logic [EXP_W-1:0] SHINE_RESET = 8'd16;
	localparam logic [P_W-1:0]   P_ONE       = 35'h0_0001_0000;
	localparam logic [P_W-1:0]   P_CAP       = 35'h4_0000_0000;
	localparam logic [H_W-1:0]   H_CAP       = 36'h8_0000_0000;
	localparam logic [OUT_W-1:0] OUT_MAX     = 17'h1ffff;

	typedef struct packed {
		logic              neg;    // light behind the surface
		logic              spec;   // specular term needs to be worked out
		logic [D_W-1:0]    d;
		logic [DOT_W-1:0]  dot;
		logic [NORM_W-1:0] norm2;
	} pls_entry_t;

	typedef struct packed {
		logic [COEF_W-1:0] diff_r;
		logic [COEF_W-1:0] diff_g;
		logic [COEF_W-1:0] diff_b;
		logic [COEF_W-1:0] spec_r;
		logic [COEF_W-1:0] spec_g;
		logic [COEF_W-1:0] spec_b;
		logic [EXP_W-1:0]  shine;
	} pls_cfg_t;

endpackage
`default_nettype wire

### src/phong_light_shade.sv
// Channel   Handshake          Payload
// input     push / full        view_xyz, norm_xyz, light_xyz (Q2.14)
// result    pop / empty        red_out, green_out, blue_out (Q1.16), faces_light
// config    APB psel/penable   7 registers at 4*i, pready tied high
//
// The front pipeline takes one transfer per cycle while full is low and feeds the queue.
// The back sequencer goes straight to the colour step when the light is behind or no highlight
// exists, else it first runs 23 sqrt steps, 41 divide steps and shine_exponent power steps.
// full rises when front pipeline plus queue hold QUEUE_DEPTH items; the back keeps
// working while a result waits on the output register. Reset clears control only.
`timescale 1ns / 1ps
`default_nettype none
module phong_light_shade #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic signed [15:0]     view_x,
	input  wire logic signed [15:0]     view_y,
	input  wire logic signed [15:0]     view_z,
	input  wire logic signed [15:0]     norm_x,
	input  wire logic signed [15:0]     norm_y,
	input  wire logic signed [15:0]     norm_z,
	input  wire logic signed [15:0]     light_x,
	input  wire logic signed [15:0]     light_y,
	input  wire logic signed [15:0]     light_z,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [16:0]                 red_out,
	output logic [16:0]                 green_out,
	output logic [16:0]                 blue_out,
	output logic                        faces_light,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [4:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	pls_pkg::pls_cfg_t   cfg_q;
	pls_pkg::pls_entry_t fe_entry, q_entry;
	logic fe_valid, q_empty, q_pop, accept, wr_en;
	logic [OCC_W-1:0] occ_q;
	logic [2:0] reg_idx;

	assign accept  = push && !full;
	assign full    = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// occupancy counts items in the front pipeline as well as in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && !q_pop) begin
			occ_q <= occ_q + 1'b1;
		end else if (q_pop && !accept) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_r <= '0;
			cfg_q.diff_g <= '0;
			cfg_q.diff_b <= '0;
			cfg_q.spec_r <= '0;
			cfg_q.spec_g <= '0;
			cfg_q.spec_b <= '0;
			cfg_q.shine  <= pls_pkg::SHINE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				pls_pkg::REG_DIFF_R: cfg_q.diff_r <= pwdata[15:0];
				pls_pkg::REG_DIFF_G: cfg_q.diff_g <= pwdata[15:0];
				pls_pkg::REG_DIFF_B: cfg_q.diff_b <= pwdata[15:0];
				pls_pkg::REG_SPEC_R: cfg_q.spec_r <= pwdata[15:0];
				pls_pkg::REG_SPEC_G: cfg_q.spec_g <= pwdata[15:0];
				pls_pkg::REG_SPEC_B: cfg_q.spec_b <= pwdata[15:0];
				pls_pkg::REG_SHINE:  cfg_q.shine  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pls_pkg::REG_DIFF_R: prdata = 32'(cfg_q.diff_r);
			pls_pkg::REG_DIFF_G: prdata = 32'(cfg_q.diff_g);
			pls_pkg::REG_DIFF_B: prdata = 32'(cfg_q.diff_b);
			pls_pkg::REG_SPEC_R: prdata = 32'(cfg_q.spec_r);
			pls_pkg::REG_SPEC_G: prdata = 32'(cfg_q.spec_g);
			pls_pkg::REG_SPEC_B: prdata = 32'(cfg_q.spec_b);
			pls_pkg::REG_SHINE:  prdata = 32'(cfg_q.shine);
			default:             prdata = '0;
		endcase
	end

	pls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.view_x    (view_x),
		.view_y    (view_y),
		.view_z    (view_z),
		.norm_x    (norm_x),
		.norm_y    (norm_y),
		.norm_z    (norm_z),
		.light_x   (light_x),
		.light_y   (light_y),
		.light_z   (light_z),
		.out_valid (fe_valid),
		.out_entry (fe_entry)
	);

	pls_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_valid),
		.wdata  (fe_entry),
		.pop    (q_pop),
		.rdata  (q_entry),
		.empty  (q_empty)
	);

	pls_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.cfg         (cfg_q),
		.pop         (pop),
		.empty       (empty),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.faces_light (faces_light)
	);

endmodule
`default_nettype wire

### src/pls_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pls_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [15:0]      view_x,
	input  wire logic signed [15:0]      view_y,
	input  wire logic signed [15:0]      view_z,
	input  wire logic signed [15:0]      norm_x,
	input  wire logic signed [15:0]      norm_y,
	input  wire logic signed [15:0]      norm_z,
	input  wire logic signed [15:0]      light_x,
	input  wire logic signed [15:0]      light_y,
	input  wire logic signed [15:0]      light_z,
	output logic                         out_valid,
	output pls_pkg::pls_entry_t          out_entry
);

	logic signed [15:0] v_in [3];
	logic signed [15:0] n_in [3];
	logic signed [15:0] l_in [3];

	assign v_in[0] = view_x;
	assign v_in[1] = view_y;
	assign v_in[2] = view_z;
	assign n_in[0] = norm_x;
	assign n_in[1] = norm_y;
	assign n_in[2] = norm_z;
	assign l_in[0] = light_x;
	assign l_in[1] = light_y;
	assign l_in[2] = light_z;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [31:0] nl_s1 [3];
	logic signed [15:0] v_s1 [3], n_s1 [3], l_s1 [3];
	logic signed [15:0] v_s2 [3], n_s2 [3], l_s2 [3];
	logic signed [15:0] v_s3 [3], v_s4 [3];
	logic [pls_pkg::D_W-1:0] d_s2, d_s3, d_s4, d_s5;
	logic neg_s2, neg_s3, neg_s4, neg_s5;
	logic signed [50:0] full_s3 [3];
	logic signed [20:0] r_s4 [3];
	logic signed [36:0] rv_s5 [3];
	logic [41:0] rr_s5 [3];
	pls_pkg::pls_entry_t entry_s6;

	logic signed [33:0] nlsum_c, dsig_c;
	logic signed [48:0] m_c [3];
	logic signed [50:0] full_c [3];
	logic signed [50:0] q_c [3];
	logic signed [50:0] rq_c [3];
	logic signed [38:0] dsum_c, dot_c;
	logic [pls_pkg::NORM_W-1:0] nsum_c;

	always_comb begin
		nlsum_c = 34'(nl_s1[0]) + 34'(nl_s1[1]) + 34'(nl_s1[2]);
		dsig_c  = -nlsum_c;
		for (int i = 0; i < 3; i++) begin
			m_c[i]    = $signed({1'b0, d_s2}) * n_s2[i];
			full_c[i] = (51'(m_c[i]) <<< 1) + (51'(l_s2[i]) <<< 28);
			// truncate toward zero
			q_c[i]    = full_s3[i] >>> 28;
			rq_c[i]   = q_c[i] + 51'(full_s3[i][50] && (|full_s3[i][27:0]));
		end
		dsum_c = 39'(rv_s5[0]) + 39'(rv_s5[1]) + 39'(rv_s5[2]);
		dot_c  = -dsum_c;
		nsum_c = rr_s5[0] + rr_s5[1] + rr_s5[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nl_s1[i]   <= n_in[i] * l_in[i];
			v_s1[i]    <= v_in[i];
			n_s1[i]    <= n_in[i];
			l_s1[i]    <= l_in[i];
			v_s2[i]    <= v_s1[i];
			n_s2[i]    <= n_s1[i];
			l_s2[i]    <= l_s1[i];
			full_s3[i] <= full_c[i];
			v_s3[i]    <= v_s2[i];
			r_s4[i]    <= rq_c[i][20:0];
			v_s4[i]    <= v_s3[i];
			rv_s5[i]   <= r_s4[i] * v_s4[i];
			rr_s5[i]   <= r_s4[i] * r_s4[i];
		end
		d_s2   <= dsig_c[31:0];
		neg_s2 <= dsig_c[33];
		d_s3   <= d_s2;
		neg_s3 <= neg_s2;
		d_s4   <= d_s3;
		neg_s4 <= neg_s3;
		d_s5   <= d_s4;
		neg_s5 <= neg_s4;
		entry_s6.neg   <= neg_s5;
		entry_s6.spec  <= !neg_s5 && !dot_c[38] && (dot_c != '0) && (nsum_c != '0);
		entry_s6.d     <= d_s5;
		entry_s6.dot   <= dot_c[36:0];
		entry_s6.norm2 <= nsum_c;
	end

	assign out_valid = vld_s6;
	assign out_entry = entry_s6;

endmodule
`default_nettype wire

### src/pls_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module pls_fifo #(
	parameter int DEPTH = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire pls_pkg::pls_entry_t  wdata,
	input  wire logic                 pop,
	output pls_pkg::pls_entry_t       rdata,
	output logic                      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pls_pkg::pls_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (cnt_q == '0);

endmodule
`default_nettype wire

### src/pls_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pls_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_empty,
	input  wire pls_pkg::pls_entry_t          q_entry,
	output logic                              q_pop,
	input  wire pls_pkg::pls_cfg_t            cfg,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [pls_pkg::OUT_W-1:0]         red_out,
	output logic [pls_pkg::OUT_W-1:0]         green_out,
	output logic [pls_pkg::OUT_W-1:0]         blue_out,
	output logic                              faces_light
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SQRT  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_POW_A = 3'd3;
	localparam logic [2:0] S_POW_B = 3'd4;
	localparam logic [2:0] S_COLOR = 3'd5;

	localparam logic [5:0] SQRT_LAST = 6'd22;
	localparam logic [5:0] DIV_LAST  = 6'd40;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic [5:0] cnt_q;
	logic [pls_pkg::EXP_W-1:0] ecnt_q;
	logic       neg_q;
	logic [pls_pkg::D_W-1:0] d_q;
	logic [45:0] num_q;
	logic [46:0] res_q;
	logic [45:0] bit_q;
	logic [22:0] rem_q;
	logic [40:0] dvd_q;
	logic [pls_pkg::H_W-1:0] h_q;
	logic [pls_pkg::P_W-1:0] p_q;
	logic [52:0] acc_q;
	logic [pls_pkg::OUT_W-1:0] red_q, green_q, blue_q;
	logic faces_q;

	logic take, fire;
	logic [46:0] sq_sum_c;
	logic        sq_ge_c;
	logic [23:0] rem_sh_c, rem_nx_c;
	logic        dv_ge_c;
	logic [40:0] q_nx_c;
	logic [pls_pkg::H_W-1:0] h_nx_c;
	logic [52:0] mul_lo_c, mul_hi_c;
	logic [70:0] prod_c;
	logic [54:0] prod_sh_c;
	logic [pls_pkg::P_W-1:0] p_nx_c;
	logic [pls_pkg::COEF_W-1:0] dcoef_c [3], scoef_c [3];
	logic [47:0] dprod_c [3];
	logic [50:0] sprod_c [3];
	logic [35:0] csum_c [3];
	logic [pls_pkg::OUT_W-1:0] col_c [3];

	always_comb begin
		take = (state_q == S_IDLE) && !q_empty;
		fire = (state_q == S_COLOR) && (!out_valid_q || pop);

		sq_sum_c = res_q + {1'b0, bit_q};
		sq_ge_c  = {1'b0, num_q} >= sq_sum_c;

		rem_sh_c = {rem_q, dvd_q[40]};
		dv_ge_c  = rem_sh_c >= {1'b0, res_q[22:0]};
		rem_nx_c = dv_ge_c ? rem_sh_c - {1'b0, res_q[22:0]} : rem_sh_c;
		q_nx_c   = {dvd_q[39:0], dv_ge_c};
		// above 2^35 the first step already hits the cap, so clamping is exact
		h_nx_c   = (q_nx_c > 41'(pls_pkg::H_CAP)) ? pls_pkg::H_CAP : q_nx_c[35:0];

		mul_lo_c  = p_q * h_q[17:0];
		mul_hi_c  = p_q * h_q[35:18];
		prod_c    = 71'(acc_q) + {mul_hi_c, 18'd0};
		prod_sh_c = prod_c[70:16];
		p_nx_c    = (prod_sh_c > 55'(pls_pkg::P_CAP)) ? pls_pkg::P_CAP : prod_sh_c[34:0];

		dcoef_c[0] = cfg.diff_r;
		dcoef_c[1] = cfg.diff_g;
		dcoef_c[2] = cfg.diff_b;
		scoef_c[0] = cfg.spec_r;
		scoef_c[1] = cfg.spec_g;
		scoef_c[2] = cfg.spec_b;
		for (int i = 0; i < 3; i++) begin
			dprod_c[i] = dcoef_c[i] * d_q;
			sprod_c[i] = scoef_c[i] * p_q;
			csum_c[i]  = 36'(dprod_c[i][47:28]) + 36'(sprod_c[i][50:16]);
			if (neg_q)
				col_c[i] = '0;
			else if (csum_c[i] > 36'(pls_pkg::OUT_MAX))
				col_c[i] = pls_pkg::OUT_MAX;
			else
				col_c[i] = csum_c[i][16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take)
						state_q <= (q_entry.neg || !q_entry.spec) ? S_COLOR : S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == '0)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= (cfg.shine == '0) ? S_COLOR : S_POW_A;
				end
				S_POW_A: state_q <= S_POW_B;
				S_POW_B: begin
					state_q <= (ecnt_q == 8'd1) ? S_COLOR : S_POW_A;
				end
				S_COLOR: begin
					if (fire)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					neg_q <= q_entry.neg;
					d_q   <= q_entry.d;
					p_q   <= '0;
					num_q <= {q_entry.norm2, 4'd0};
					res_q <= '0;
					bit_q <= 46'd1 << 44;
					cnt_q <= SQRT_LAST;
					dvd_q <= {q_entry.dot, 4'd0};
					rem_q <= '0;
				end
			end
			S_SQRT: begin
				if (sq_ge_c) begin
					num_q <= num_q - sq_sum_c[45:0];
					res_q <= (res_q >> 1) + {1'b0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= (cnt_q == '0) ? DIV_LAST : cnt_q - 1'b1;
			end
			S_DIV: begin
				dvd_q <= q_nx_c;
				rem_q <= rem_nx_c[22:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					h_q    <= h_nx_c;
					p_q    <= pls_pkg::P_ONE;
					ecnt_q <= cfg.shine;
				end
			end
			S_POW_A: acc_q <= mul_lo_c;
			S_POW_B: begin
				p_q    <= p_nx_c;
				ecnt_q <= ecnt_q - 1'b1;
			end
			S_COLOR: begin
				if (fire) begin
					red_q   <= col_c[0];
					green_q <= col_c[1];
					blue_q  <= col_c[2];
					faces_q <= !neg_q;
				end
			end
			default: ;
		endcase
	end

	assign q_pop       = take;
	assign empty       = !out_valid_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign faces_light = faces_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> res_q[22:0] != '0)
		else $error("divide by zero length");

	a_pow_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POW_A || state_q == S_POW_B || state_q == S_COLOR) |->
		p_q <= pls_pkg::P_CAP)
		else $error("power term above cap");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q != S_IDLE)
		else $error("queue entry taken but sequencer idle");

	a_color_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COLOR && out_valid_q && !pop) |=> state_q == S_COLOR)
		else $error("result dropped while output register full");

endmodule
`default_nettype wire
